// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the byte buffer queue RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lbbq_pkg.sv =====
// Package for the byte buffer queue: sizes, codes, payload and control structs.
// No dependencies; used by every module of the block except lbbq_ram.
package lbbq_pkg;

   // Storage and field sizes.
   localparam int DEPTH     = 1024;
   localparam int MAX_BURST = 64;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int IDX_W     = $clog2(DEPTH + 1);
   localparam int CNT_W     = 11;
   localparam int BYTE_W    = 8;
   localparam int RUN_W     = (IDX_W > CNT_W) ? IDX_W : CNT_W;
   localparam int CMP_W     = RUN_W + 1;

   localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(1024);

   // Request codes.
   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_BLOCK  = 3'd2,
      OP_FILL   = 3'd3,
      OP_REWIND = 3'd4,
      OP_REDACT = 3'd5,
      OP_FOLD   = 3'd6,
      OP_BAD    = 3'd7
   } lbbq_op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SIZE  = 2'd1,
      ST_SPACE = 2'd2,
      ST_RSVD  = 2'd3
   } lbbq_status_type;

   // Index update selects.
   typedef enum logic [1:0] {
      IDX_HOLD  = 2'd0,
      IDX_INC   = 2'd1,
      IDX_SUB   = 2'd2,
      IDX_CLEAR = 2'd3
   } lbbq_idx_op_type;

   // Amount field selects.
   typedef enum logic [1:0] {
      AMT_ZERO = 2'd0,
      AMT_ONE  = 2'd1,
      AMT_CNT  = 2'd2,
      AMT_REG  = 2'd3
   } lbbq_amt_type;

   // Run length load selects.
   typedef enum logic [1:0] {
      LD_ONE   = 2'd0,
      LD_CLAMP = 2'd1,
      LD_CNT   = 2'd2,
      LD_AVAIL = 2'd3
   } lbbq_ld_type;

   // Input item.
   typedef struct packed {
      logic [2:0]        req_type;
      logic [BYTE_W-1:0] data_byte;
      logic [CNT_W-1:0]  count;
   } lbbq_req_type;

   // Result item.
   typedef struct packed {
      logic [1:0]        status;
      logic [BYTE_W-1:0] byte_out;
      logic              byte_valid;
      logic              last;
      logic [CNT_W-1:0]  amount;
   } lbbq_rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic            ld_req;
      logic            load_rsp;
      lbbq_status_type rsp_status;
      lbbq_amt_type    rsp_amt;
      logic            rsp_byte;
      lbbq_idx_op_type ri_op;
      lbbq_idx_op_type wi_op;
      logic            wr_en;
      logic            wr_fold;
      logic            rd_en;
      logic            rd_next;
      logic            ld_run;
      lbbq_ld_type     ld_sel;
      logic            dec_run;
   } lbbq_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      lbbq_op_type op;
      logic        push_ok;
      logic        fill_ok;
      logic        cnt_zero;
      logic        size_bad;
      logic        avail_zero;
      logic        rewind_ok;
      logic        redact_ok;
      logic        fold_ok;
      logic        run_last;
      logic        slot_free;
   } lbbq_stat_type;

endpackage

// ===== hdl/linear_byte_buffer_queue.sv =====
// Linear byte buffer queue with block pop, fill, rewind, redact and fold down.
// Line-by-line usage notes follow.
// Channels: req_* carries one request per transfer (valid/ready), rsp_* returns
// results (valid/ready), csr_* writes the capacity register (no wait, no read-back).
// Push, rewind, redact and every error give a single result: the request is
// registered, worked out in the execute state and its result loaded into the
// output register; a pop first reads its byte from the store. Block pop then
// streams one byte per cycle while the receiver takes them; fill writes its bytes
// and fold moves each kept byte in turn, with one result at the end of each.
// A new request is taken only once the previous one has finished its work.
// A finished result sits in the output register, so the next request can be taken
// while it waits; a stalled receiver holds the block only when a new result is due.
// Reset (synchronous, active high) clears both indices, sets capacity to 1024 and
// empties the output register; store contents are undefined until written.
// Depends on lbbq_pkg, lbbq_ctrl, lbbq_datapath and lbbq_ram.
module linear_byte_buffer_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lbbq_pkg::lbbq_req_type        req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lbbq_pkg::lbbq_rsp_type        rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [lbbq_pkg::CNT_W-1:0]    csr_wr_data
);

   lbbq_pkg::lbbq_cmd_type  cmd;
   lbbq_pkg::lbbq_stat_type stat;

   // Sequencing of each request.
   lbbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Indices, store and result register.
   lbbq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

// ===== hdl/lbbq_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies; instantiated by the datapath for the byte store.
module lbbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lbbq_ctrl.sv =====
// Controller state machine of the byte buffer queue.
// Depends on lbbq_pkg and assert_macros.svh; drives the datapath commands.
`include "assert_macros.svh"

module lbbq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lbbq_pkg::lbbq_stat_type stat,
   output lbbq_pkg::lbbq_cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_EXEC = 6'b000010,
      S_BOUT = 6'b000100,
      S_FILL = 6'b001000,
      S_FOLD = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.ld_req = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (stat.op)
               lbbq_pkg::OP_PUSH: begin
                  if (stat.slot_free) begin
                     cmd.load_rsp = 1'b1;
                     state_in     = S_IDLE;
                     if (stat.push_ok) begin
                        cmd.wr_en      = 1'b1;
                        cmd.wi_op      = lbbq_pkg::IDX_INC;
                        cmd.rsp_status = lbbq_pkg::ST_OK;
                        cmd.rsp_amt    = lbbq_pkg::AMT_ONE;
                     end else begin
                        cmd.rsp_status = lbbq_pkg::ST_SPACE;
                        cmd.rsp_amt    = lbbq_pkg::AMT_ZERO;
                     end
                  end
               end
               lbbq_pkg::OP_POP: begin
                  if (stat.avail_zero) begin
                     if (stat.slot_free) begin
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_status = lbbq_pkg::ST_SPACE;
                        cmd.rsp_amt    = lbbq_pkg::AMT_ZERO;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     cmd.ld_run = 1'b1;
                     cmd.ld_sel = lbbq_pkg::LD_ONE;
                     cmd.rd_en  = 1'b1;
                     state_in   = S_BOUT;
                  end
               end
               lbbq_pkg::OP_BLOCK: begin
                  if (stat.size_bad || stat.avail_zero) begin
                     if (stat.slot_free) begin
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_status = stat.size_bad ? lbbq_pkg::ST_SIZE : lbbq_pkg::ST_OK;
                        cmd.rsp_amt    = lbbq_pkg::AMT_ZERO;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     cmd.ld_run = 1'b1;
                     cmd.ld_sel = lbbq_pkg::LD_CLAMP;
                     cmd.rd_en  = 1'b1;
                     state_in   = S_BOUT;
                  end
               end
               lbbq_pkg::OP_FILL: begin
                  if (!stat.fill_ok || stat.cnt_zero) begin
                     if (stat.slot_free) begin
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_status = stat.fill_ok ? lbbq_pkg::ST_OK : lbbq_pkg::ST_SPACE;
                        cmd.rsp_amt    = lbbq_pkg::AMT_ZERO;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     cmd.ld_run = 1'b1;
                     cmd.ld_sel = lbbq_pkg::LD_CNT;
                     state_in   = S_FILL;
                  end
               end
               lbbq_pkg::OP_REWIND: begin
                  if (stat.slot_free) begin
                     cmd.load_rsp = 1'b1;
                     state_in     = S_IDLE;
                     if (stat.rewind_ok) begin
                        cmd.ri_op      = lbbq_pkg::IDX_SUB;
                        cmd.rsp_status = lbbq_pkg::ST_OK;
                        cmd.rsp_amt    = lbbq_pkg::AMT_CNT;
                     end else begin
                        cmd.rsp_status = lbbq_pkg::ST_SIZE;
                        cmd.rsp_amt    = lbbq_pkg::AMT_ZERO;
                     end
                  end
               end
               lbbq_pkg::OP_REDACT: begin
                  if (stat.slot_free) begin
                     cmd.load_rsp = 1'b1;
                     state_in     = S_IDLE;
                     if (stat.redact_ok) begin
                        cmd.wi_op      = lbbq_pkg::IDX_SUB;
                        cmd.rsp_status = lbbq_pkg::ST_OK;
                        cmd.rsp_amt    = lbbq_pkg::AMT_CNT;
                     end else begin
                        cmd.rsp_status = lbbq_pkg::ST_SIZE;
                        cmd.rsp_amt    = lbbq_pkg::AMT_ZERO;
                     end
                  end
               end
               lbbq_pkg::OP_FOLD: begin
                  if (!stat.fold_ok || stat.avail_zero) begin
                     if (stat.slot_free) begin
                        cmd.load_rsp = 1'b1;
                        cmd.rsp_amt  = lbbq_pkg::AMT_ZERO;
                        state_in     = S_IDLE;
                        if (stat.fold_ok) begin
                           // Nothing unread: both indices return to zero.
                           cmd.ri_op      = lbbq_pkg::IDX_CLEAR;
                           cmd.wi_op      = lbbq_pkg::IDX_CLEAR;
                           cmd.rsp_status = lbbq_pkg::ST_OK;
                        end else begin
                           cmd.rsp_status = lbbq_pkg::ST_SPACE;
                        end
                     end
                  end else begin
                     // Fetch the first source byte; the write index becomes the destination.
                     cmd.ld_run = 1'b1;
                     cmd.ld_sel = lbbq_pkg::LD_AVAIL;
                     cmd.rd_en  = 1'b1;
                     cmd.ri_op  = lbbq_pkg::IDX_INC;
                     cmd.wi_op  = lbbq_pkg::IDX_CLEAR;
                     state_in   = S_FOLD;
                  end
               end
               default: begin
                  if (stat.slot_free) begin
                     cmd.load_rsp   = 1'b1;
                     cmd.rsp_status = lbbq_pkg::ST_SIZE;
                     cmd.rsp_amt    = lbbq_pkg::AMT_ZERO;
                     state_in       = S_IDLE;
                  end
               end
            endcase
         end
         S_BOUT: begin
            // One popped byte per transfer; prefetch the next one alongside.
            if (stat.slot_free) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_byte   = 1'b1;
               cmd.rsp_status = lbbq_pkg::ST_OK;
               cmd.rsp_amt    = lbbq_pkg::AMT_REG;
               cmd.ri_op      = lbbq_pkg::IDX_INC;
               cmd.dec_run    = 1'b1;
               if (stat.run_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_next = 1'b1;
               end
            end
         end
         S_FILL: begin
            cmd.wr_en   = 1'b1;
            cmd.wi_op   = lbbq_pkg::IDX_INC;
            cmd.dec_run = 1'b1;
            if (stat.run_last) begin
               state_in = S_DONE;
            end
         end
         S_FOLD: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_fold = 1'b1;
            cmd.wi_op   = lbbq_pkg::IDX_INC;
            cmd.dec_run = 1'b1;
            if (stat.run_last) begin
               cmd.ri_op = lbbq_pkg::IDX_CLEAR;
               state_in  = S_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.ri_op = lbbq_pkg::IDX_INC;
            end
         end
         S_DONE: begin
            if (stat.slot_free) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = lbbq_pkg::ST_OK;
               cmd.rsp_amt    = lbbq_pkg::AMT_REG;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The last byte of a pop ends the request.
   `ASSERT_NEXT(a_last_byte_idle, clock, reset, cmd.load_rsp && cmd.rsp_byte && stat.run_last, state_ff == S_IDLE, "pop did not end after its last byte")
   // Store writes come only from push, fill or fold work.
   `ASSERT_IMPLY(a_write_states, clock, reset, cmd.wr_en, state_ff == S_EXEC || state_ff == S_FILL || state_ff == S_FOLD, "store write outside a writing state")

endmodule

// ===== hdl/lbbq_datapath.sv =====
// Datapath of the byte buffer queue: indices, capacity, run counter, store, result register.
// Depends on lbbq_pkg, lbbq_ram and assert_macros.svh; commanded by lbbq_ctrl.
`include "assert_macros.svh"

module lbbq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  lbbq_pkg::lbbq_req_type            req_payload,
   output lbbq_pkg::lbbq_rsp_type            rsp_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              csr_wr_en,
   input  logic [lbbq_pkg::CNT_W-1:0]        csr_wr_data,
   input  lbbq_pkg::lbbq_cmd_type            cmd,
   output lbbq_pkg::lbbq_stat_type           stat
);

   localparam int IW = lbbq_pkg::IDX_W;
   localparam int CW = lbbq_pkg::CNT_W;
   localparam int XW = lbbq_pkg::CMP_W;
   localparam int RW = lbbq_pkg::RUN_W;
   localparam int AW = lbbq_pkg::ADDR_W;
   localparam int BW = lbbq_pkg::BYTE_W;

   lbbq_pkg::lbbq_req_type req_ff;
   lbbq_pkg::lbbq_rsp_type rsp_ff;
   lbbq_pkg::lbbq_rsp_type rsp_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [IW-1:0]          ri_ff;
   logic [IW-1:0]          ri_in;
   logic [IW-1:0]          wi_ff;
   logic [IW-1:0]          wi_in;
   logic [CW-1:0]          capacity_ff;
   logic [RW-1:0]          run_ff;
   logic [RW-1:0]          run_in;
   logic [RW-1:0]          amt_ff;
   logic [RW-1:0]          amt_in;
   logic [RW-1:0]          run_load;

   logic [XW-1:0] cap_x;
   logic [XW-1:0] lim_x;
   logic [XW-1:0] wi_x;
   logic [XW-1:0] ri_x;
   logic [XW-1:0] cnt_x;
   logic [XW-1:0] av_x;
   logic [XW-1:0] clamp_x;

   logic [AW-1:0] rd_addr;
   logic [BW-1:0] wr_data;
   logic [BW-1:0] rd_data;

   // Limit and availability.
   assign cap_x   = XW'(capacity_ff);
   assign lim_x   = (cap_x > XW'(lbbq_pkg::DEPTH)) ? XW'(lbbq_pkg::DEPTH) : cap_x;
   assign wi_x    = XW'(wi_ff);
   assign ri_x    = XW'(ri_ff);
   assign cnt_x   = XW'(req_ff.count);
   assign av_x    = (wi_x > ri_x) ? (wi_x - ri_x) : '0;
   assign clamp_x = (cnt_x < av_x) ? cnt_x : av_x;

   // Status toward the controller.
   always_comb begin
      stat            = '0;
      stat.op         = lbbq_pkg::lbbq_op_type'(req_ff.req_type);
      stat.push_ok    = (wi_x + XW'(1)) <= lim_x;
      stat.fill_ok    = (wi_x + cnt_x) <= lim_x;
      stat.cnt_zero   = (req_ff.count == '0);
      stat.size_bad   = (req_ff.count == '0) || (cnt_x > XW'(lbbq_pkg::MAX_BURST));
      stat.avail_zero = (av_x == '0);
      stat.rewind_ok  = cnt_x <= ri_x;
      stat.redact_ok  = cnt_x <= wi_x;
      stat.fold_ok    = av_x <= ri_x;
      stat.run_last   = (run_ff == RW'(1));
      stat.slot_free  = !rsp_valid_ff || rsp_ready;
   end

   // Index updates.
   always_comb begin
      unique case (cmd.ri_op)
         lbbq_pkg::IDX_HOLD:  ri_in = ri_ff;
         lbbq_pkg::IDX_INC:   ri_in = ri_ff + IW'(1);
         lbbq_pkg::IDX_SUB:   ri_in = ri_ff - IW'(req_ff.count);
         lbbq_pkg::IDX_CLEAR: ri_in = '0;
         default:             ri_in = ri_ff;
      endcase
      unique case (cmd.wi_op)
         lbbq_pkg::IDX_HOLD:  wi_in = wi_ff;
         lbbq_pkg::IDX_INC:   wi_in = wi_ff + IW'(1);
         lbbq_pkg::IDX_SUB:   wi_in = wi_ff - IW'(req_ff.count);
         lbbq_pkg::IDX_CLEAR: wi_in = '0;
         default:             wi_in = wi_ff;
      endcase
   end

   // Run length of a multi-cycle request and its reported amount.
   always_comb begin
      unique case (cmd.ld_sel)
         lbbq_pkg::LD_ONE:   run_load = RW'(1);
         lbbq_pkg::LD_CLAMP: run_load = RW'(clamp_x);
         lbbq_pkg::LD_CNT:   run_load = RW'(cnt_x);
         lbbq_pkg::LD_AVAIL: run_load = RW'(av_x);
         default:            run_load = RW'(1);
      endcase
      if (cmd.ld_run) begin
         run_in = run_load;
         amt_in = run_load;
      end else begin
         run_in = cmd.dec_run ? (run_ff - RW'(1)) : run_ff;
         amt_in = amt_ff;
      end
   end

   // Result assembly.
   always_comb begin
      rsp_in            = '0;
      rsp_in.status     = cmd.rsp_status;
      rsp_in.byte_valid = cmd.rsp_byte;
      rsp_in.byte_out   = cmd.rsp_byte ? rd_data : '0;
      rsp_in.last       = cmd.rsp_byte ? stat.run_last : 1'b1;
      unique case (cmd.rsp_amt)
         lbbq_pkg::AMT_ZERO: rsp_in.amount = '0;
         lbbq_pkg::AMT_ONE:  rsp_in.amount = CW'(1);
         lbbq_pkg::AMT_CNT:  rsp_in.amount = req_ff.count;
         lbbq_pkg::AMT_REG:  rsp_in.amount = CW'(amt_ff);
         default:            rsp_in.amount = '0;
      endcase
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ri_ff        <= '0;
         wi_ff        <= '0;
         capacity_ff  <= lbbq_pkg::CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
         run_ff       <= '0;
      end else begin
         ri_ff        <= ri_in;
         wi_ff        <= wi_in;
         rsp_valid_ff <= rsp_valid_in;
         run_ff       <= run_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      amt_ff <= amt_in;
      if (cmd.ld_req) begin
         req_ff <= req_payload;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   // Byte store: writes at the write index, reads at the read index or one past it.
   assign rd_addr = cmd.rd_next ? AW'(ri_ff + IW'(1)) : AW'(ri_ff);
   assign wr_data = cmd.wr_fold ? rd_data : req_ff.data_byte;

   lbbq_ram #(
      .WIDTH (BW),
      .DEPTH (lbbq_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (AW'(wi_ff)),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_payload = rsp_ff;
   assign rsp_valid   = rsp_valid_ff;

   // Indices never go beyond the store depth.
   `ASSERT_ALWAYS(a_wi_range, clock, reset, wi_ff <= IW'(lbbq_pkg::DEPTH), "write index beyond store")
   `ASSERT_ALWAYS(a_ri_range, clock, reset, ri_ff <= IW'(lbbq_pkg::DEPTH), "read index beyond store")
   // A store write never lands past the end of the store.
   `ASSERT_IMPLY(a_wr_addr, clock, reset, cmd.wr_en, wi_ff < IW'(lbbq_pkg::DEPTH), "store write out of range")

endmodule

// ===== test/linear_byte_buffer_queue_test.sv =====
// Self-checking testbench for the linear byte buffer queue: directed table, then random phases.
// It predicts results or takes them from typed rows, then checks them in order of arrival.
// Depends on lbbq_pkg and linear_byte_buffer_queue.
module linear_byte_buffer_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = lbbq_pkg::CNT_W;
   localparam int BW = lbbq_pkg::BYTE_W;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   lbbq_pkg::lbbq_req_type req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   lbbq_pkg::lbbq_rsp_type rsp_payload;
   logic                   csr_wr_en;
   logic [CW-1:0]          csr_wr_data;

   linear_byte_buffer_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predicted buffer state and the results still owed by the block.
   logic [BW-1:0]          buffer_bytes [0:lbbq_pkg::DEPTH-1];
   logic [CW-1:0]          read_pos;
   logic [CW-1:0]          write_pos;
   logic [CW-1:0]          capacity_now;
   lbbq_pkg::lbbq_rsp_type results_due [$];
   int                     mismatches = 0;

   // Pacing controls for the sender and the receiver.
   bit calm;
   bit hold_off_req;
   bit hold_off_done;
   int hold_left;

   // One row of the directed table; typed rows carry their single result inline.
   typedef struct packed {
      lbbq_pkg::lbbq_op_type     op;
      logic [7:0]                data;
      logic [CW-1:0]             count;
      logic                      typed;
      lbbq_pkg::lbbq_status_type status;
      logic [CW-1:0]             amount;
   } step_row_type;

   step_row_type directed_rows [26] = '{
      '{lbbq_pkg::OP_POP,    8'h00, 11'd0,    1'b1, lbbq_pkg::ST_SPACE, 11'd0},  // pop when empty
      '{lbbq_pkg::OP_BLOCK,  8'h00, 11'd0,    1'b1, lbbq_pkg::ST_SIZE,  11'd0},  // zero bytes
      '{lbbq_pkg::OP_BLOCK,  8'h00, 11'd65,   1'b1, lbbq_pkg::ST_SIZE,  11'd0},  // above burst
      '{lbbq_pkg::OP_BLOCK,  8'h00, 11'd5,    1'b1, lbbq_pkg::ST_OK,    11'd0},  // none there
      '{lbbq_pkg::OP_FOLD,   8'h00, 11'd0,    1'b1, lbbq_pkg::ST_OK,    11'd0},  // empty fold
      '{lbbq_pkg::OP_REWIND, 8'h00, 11'd1,    1'b1, lbbq_pkg::ST_SIZE,  11'd0},  // past index 0
      '{lbbq_pkg::OP_REDACT, 8'h00, 11'd1024, 1'b1, lbbq_pkg::ST_SIZE,  11'd0},  // past index 0
      '{lbbq_pkg::OP_BAD,    8'hFF, 11'd1024, 1'b1, lbbq_pkg::ST_SIZE,  11'd0},  // unknown type
      '{lbbq_pkg::OP_PUSH,   8'h00, 11'd0,    1'b1, lbbq_pkg::ST_OK,    11'd1},
      '{lbbq_pkg::OP_PUSH,   8'hFF, 11'd0,    1'b1, lbbq_pkg::ST_OK,    11'd1},
      '{lbbq_pkg::OP_FILL,   8'hA5, 11'd0,    1'b1, lbbq_pkg::ST_OK,    11'd0},  // zero bytes
      '{lbbq_pkg::OP_FILL,   8'hA5, 11'd1024, 1'b1, lbbq_pkg::ST_SPACE, 11'd0},  // past limit
      '{lbbq_pkg::OP_FILL,   8'h5A, 11'd6,    1'b1, lbbq_pkg::ST_OK,    11'd6},
      '{lbbq_pkg::OP_POP,    8'h00, 11'd0,    1'b0, lbbq_pkg::ST_OK,    11'd0},
      '{lbbq_pkg::OP_BLOCK,  8'h00, 11'd64,   1'b0, lbbq_pkg::ST_OK,    11'd0},  // clamped
      '{lbbq_pkg::OP_FOLD,   8'h00, 11'd0,    1'b0, lbbq_pkg::ST_OK,    11'd0},
      '{lbbq_pkg::OP_FILL,   8'h3C, 11'd10,   1'b1, lbbq_pkg::ST_OK,    11'd10},
      '{lbbq_pkg::OP_PUSH,   8'h81, 11'd0,    1'b1, lbbq_pkg::ST_OK,    11'd1},
      '{lbbq_pkg::OP_POP,    8'h00, 11'd0,    1'b0, lbbq_pkg::ST_OK,    11'd0},
      '{lbbq_pkg::OP_FOLD,   8'h00, 11'd0,    1'b0, lbbq_pkg::ST_OK,    11'd0},  // overlap
      '{lbbq_pkg::OP_BLOCK,  8'h00, 11'd6,    1'b0, lbbq_pkg::ST_OK,    11'd0},
      '{lbbq_pkg::OP_FOLD,   8'h00, 11'd0,    1'b0, lbbq_pkg::ST_OK,    11'd0},  // keeps four
      '{lbbq_pkg::OP_FILL,   8'h7E, 11'd60,   1'b1, lbbq_pkg::ST_OK,    11'd60},
      '{lbbq_pkg::OP_BLOCK,  8'h00, 11'd64,   1'b0, lbbq_pkg::ST_OK,    11'd0},  // full burst
      '{lbbq_pkg::OP_REWIND, 8'h00, 11'd64,   1'b1, lbbq_pkg::ST_OK,    11'd64},
      '{lbbq_pkg::OP_REDACT, 8'h00, 11'd64,   1'b1, lbbq_pkg::ST_OK,    11'd64}
   };

   // Random phases: capacity setting and number of requests in each.
   logic [CW-1:0] phase_cap   [5] = '{11'd1024, 11'd40, 11'd2047, 11'd1, 11'd300};
   int            phase_items [5] = '{100, 70, 84, 40, 120};

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run.
   initial begin
      #5_000_000;
      $display("** linear_byte_buffer_queue: FAILED **");
      $finish;
   end

   task automatic report_mismatch(input string field, input logic [CW-1:0] got,
                                  input logic [CW-1:0] want);
      mismatches++;
      $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
   endtask

   function automatic void add_due(input lbbq_pkg::lbbq_status_type status,
                                   input logic [7:0] data,
                                   input logic valid, input logic last,
                                   input logic [CW-1:0] amount);
      lbbq_pkg::lbbq_rsp_type r;
      r.status     = status;
      r.byte_out   = data;
      r.byte_valid = valid;
      r.last       = last;
      r.amount     = amount;
      results_due.push_back(r);
   endfunction

   // Apply one request to the predicted buffer and queue the results it owes.
   task automatic run_buffer_op(input lbbq_pkg::lbbq_req_type r);
      logic [CW-1:0] lim;
      logic [CW-1:0] avail;
      logic [CW-1:0] n;
      logic [CW:0]   reach;
      lim   = (capacity_now > CW'(lbbq_pkg::DEPTH)) ? CW'(lbbq_pkg::DEPTH) : capacity_now;
      avail = (write_pos > read_pos) ? write_pos - read_pos : '0;
      n     = r.count;
      case (r.req_type)
         lbbq_pkg::OP_PUSH: begin
            reach = write_pos + 1'b1;
            if (reach > lim) begin
               add_due(lbbq_pkg::ST_SPACE, 8'h00, 1'b0, 1'b1, '0);
            end else begin
               buffer_bytes[write_pos] = r.data_byte;
               write_pos = write_pos + 1'b1;
               add_due(lbbq_pkg::ST_OK, 8'h00, 1'b0, 1'b1, 11'd1);
            end
         end
         lbbq_pkg::OP_POP: begin
            if (avail == 0) begin
               add_due(lbbq_pkg::ST_SPACE, 8'h00, 1'b0, 1'b1, '0);
            end else begin
               add_due(lbbq_pkg::ST_OK, buffer_bytes[read_pos], 1'b1, 1'b1, 11'd1);
               read_pos = read_pos + 1'b1;
            end
         end
         lbbq_pkg::OP_BLOCK: begin
            if (n == 0 || n > lbbq_pkg::MAX_BURST) begin
               add_due(lbbq_pkg::ST_SIZE, 8'h00, 1'b0, 1'b1, '0);
            end else begin
               if (n > avail) n = avail;
               if (n == 0) add_due(lbbq_pkg::ST_OK, 8'h00, 1'b0, 1'b1, '0);
               for (int i = 0; i < n; i++)
                  add_due(lbbq_pkg::ST_OK, buffer_bytes[read_pos + i], 1'b1, i == n - 1, n);
               read_pos = read_pos + n;
            end
         end
         lbbq_pkg::OP_FILL: begin
            reach = write_pos + n;
            if (reach > lim) begin
               add_due(lbbq_pkg::ST_SPACE, 8'h00, 1'b0, 1'b1, '0);
            end else begin
               for (int i = 0; i < n; i++) buffer_bytes[write_pos + i] = r.data_byte;
               write_pos = write_pos + n;
               add_due(lbbq_pkg::ST_OK, 8'h00, 1'b0, 1'b1, n);
            end
         end
         lbbq_pkg::OP_REWIND: begin
            if (n > read_pos) begin
               add_due(lbbq_pkg::ST_SIZE, 8'h00, 1'b0, 1'b1, '0);
            end else begin
               read_pos = read_pos - n;
               add_due(lbbq_pkg::ST_OK, 8'h00, 1'b0, 1'b1, n);
            end
         end
         lbbq_pkg::OP_REDACT: begin
            if (n > write_pos) begin
               add_due(lbbq_pkg::ST_SIZE, 8'h00, 1'b0, 1'b1, '0);
            end else begin
               write_pos = write_pos - n;
               add_due(lbbq_pkg::ST_OK, 8'h00, 1'b0, 1'b1, n);
            end
         end
         lbbq_pkg::OP_FOLD: begin
            // The unread bytes may only move down when they clear their destination.
            if (avail > read_pos) begin
               add_due(lbbq_pkg::ST_SPACE, 8'h00, 1'b0, 1'b1, '0);
            end else begin
               for (int i = 0; i < avail; i++) buffer_bytes[i] = buffer_bytes[read_pos + i];
               write_pos = avail;
               read_pos  = '0;
               add_due(lbbq_pkg::ST_OK, 8'h00, 1'b0, 1'b1, avail);
            end
         end
         default: add_due(lbbq_pkg::ST_SIZE, 8'h00, 1'b0, 1'b1, '0);
      endcase
   endtask

   // Random request, weighted so that most requests do real work on the buffer.
   function automatic lbbq_pkg::lbbq_req_type next_random_request();
      lbbq_pkg::lbbq_req_type r;
      int unsigned            pick;
      int unsigned            k;
      r.data_byte = BW'($urandom_range(0, 255));
      r.count     = '0;
      pick        = $urandom_range(0, 99);
      k           = $urandom_range(0, 19);
      if (pick < 28) begin
         r.req_type = lbbq_pkg::OP_PUSH;
      end else if (pick < 40) begin
         r.req_type = lbbq_pkg::OP_POP;
      end else if (pick < 56) begin
         r.req_type = lbbq_pkg::OP_BLOCK;
         if (k == 0) r.count = '0;
         else if (k == 1)
            r.count = CW'($urandom_range(lbbq_pkg::MAX_BURST + 1, lbbq_pkg::DEPTH));
         else if (k < 5) r.count = CW'($urandom_range(17, lbbq_pkg::MAX_BURST));
         else r.count = CW'($urandom_range(1, 16));
      end else if (pick < 70) begin
         r.req_type = lbbq_pkg::OP_FILL;
         if (k == 0) r.count = '0;
         else if (k == 1) r.count = CW'($urandom_range(0, lbbq_pkg::DEPTH));
         else r.count = CW'($urandom_range(1, 12));
      end else if (pick < 76) begin
         r.req_type = lbbq_pkg::OP_REWIND;
         r.count = (k < 15) ? CW'($urandom_range(0, read_pos))
                            : CW'($urandom_range(0, lbbq_pkg::DEPTH));
      end else if (pick < 82) begin
         r.req_type = lbbq_pkg::OP_REDACT;
         if (k < 12) r.count = CW'($urandom_range(0, (write_pos < 3) ? write_pos : 3));
         else if (k < 17) r.count = CW'($urandom_range(0, write_pos));
         else r.count = CW'($urandom_range(0, lbbq_pkg::DEPTH));
      end else if (pick < 96) begin
         r.req_type = lbbq_pkg::OP_FOLD;
      end else begin
         r.req_type = lbbq_pkg::OP_BAD;
      end
      return r;
   endfunction

   // Offer one request, with random idle cycles first, and predict it on transfer.
   task automatic send_req(input lbbq_pkg::lbbq_req_type r, input bit typed,
                           input lbbq_pkg::lbbq_rsp_type want);
      int held;
      while (!calm && $urandom_range(0, 99) < 29) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid   = 1'b1;
      req_payload = r;
      do @(posedge clock); while (!req_ready);
      held = results_due.size();
      run_buffer_op(r);
      // A typed row replaces the prediction with the result written in the table.
      if (typed) begin
         while (results_due.size() > held) void'(results_due.pop_back());
         results_due.push_back(want);
      end
   endtask

   // Stop offering, let every owed result arrive, then give the block some slack.
   task automatic settle(input int extra);
      @(negedge clock);
      req_valid = 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [CW-1:0] value);
      settle(4);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en    = 1'b0;
      capacity_now = value;
   endtask

   // Receiver: random stalls, one long hold-off on request, none while calm.
   initial begin
      rsp_ready     = 1'b0;
      hold_left     = 0;
      hold_off_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_off_done) begin
            hold_left     = 400;
            hold_off_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = calm || ($urandom_range(0, 99) >= 29);
         end
      end
   end

   // Check each result transfer against the oldest owed result.
   always @(posedge clock) begin : rsp_check
      lbbq_pkg::lbbq_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            report_mismatch("result with nothing due, amount", rsp_payload.amount, '0);
         end else begin
            want = results_due.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", CW'(rsp_payload.status), CW'(want.status));
            if (rsp_payload.byte_out !== want.byte_out)
               report_mismatch("byte_out", CW'(rsp_payload.byte_out), CW'(want.byte_out));
            if (rsp_payload.byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", CW'(rsp_payload.byte_valid),
                               CW'(want.byte_valid));
            if (rsp_payload.last !== want.last)
               report_mismatch("last", CW'(rsp_payload.last), CW'(want.last));
            if (rsp_payload.amount !== want.amount)
               report_mismatch("amount", rsp_payload.amount, want.amount);
         end
      end
   end

   // Stimulus: reset, directed table, then random phases at several capacities.
   initial begin : stimulus
      lbbq_pkg::lbbq_req_type req;
      lbbq_pkg::lbbq_rsp_type want;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      read_pos      = '0;
      write_pos     = '0;
      capacity_now  = lbbq_pkg::CAPACITY_RESET;
      calm          = 1'b0;
      hold_off_req  = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part runs on the capacity left by reset.
      foreach (directed_rows[i]) begin
         req.req_type   = directed_rows[i].op;
         req.data_byte  = directed_rows[i].data;
         req.count      = directed_rows[i].count;
         want           = '0;
         want.status    = directed_rows[i].status;
         want.last      = 1'b1;
         want.amount    = directed_rows[i].amount;
         send_req(req, directed_rows[i].typed, want);
      end

      for (int p = 0; p < 5; p++) begin
         set_capacity(phase_cap[p]);
         // The receiver holds off while the sender keeps offering, so the block backs up.
         if (p == 0) hold_off_req = 1'b1;
         if (p == 2) begin
            calm = 1'b1;
            // Empty the buffer, fill all of it, read it back in full bursts, then fold the indices to zero.
            req           = '0;
            req.req_type  = lbbq_pkg::OP_REDACT;
            req.count     = write_pos;
            send_req(req, 1'b0, '0);
            req.req_type  = lbbq_pkg::OP_FOLD;
            send_req(req, 1'b0, '0);
            req.req_type  = lbbq_pkg::OP_FILL;
            req.data_byte = BW'($urandom_range(0, 255));
            req.count     = CW'(lbbq_pkg::DEPTH);
            send_req(req, 1'b0, '0);
            req.req_type  = lbbq_pkg::OP_BLOCK;
            req.count     = CW'(lbbq_pkg::MAX_BURST);
            repeat (lbbq_pkg::DEPTH / lbbq_pkg::MAX_BURST) send_req(req, 1'b0, '0);
            req.req_type  = lbbq_pkg::OP_FOLD;
            send_req(req, 1'b0, '0);
         end
         repeat (phase_items[p]) send_req(next_random_request(), 1'b0, '0);
         calm = 1'b0;
      end

      settle(20);
      if (mismatches == 0)
         $display("** linear_byte_buffer_queue: PASSED **");
      else
         $display("** linear_byte_buffer_queue: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lbbq_pkg.sv
hdl/lbbq_ram.sv
hdl/lbbq_ctrl.sv
hdl/lbbq_datapath.sv
hdl/linear_byte_buffer_queue.sv
test/linear_byte_buffer_queue_test.sv
